// File: hw/rtl/tarhv_pkg.sv
`timescale 1ns / 1ps

package tarhv_pkg;

   localparam int HDR_LEN    = 512;
   localparam int OFS_W      = 10;
   localparam int SUM_W      = 17;
   localparam int VAL_W      = 24;
   localparam int SUM_BASE   = 256;
   localparam int MODE_FIRST = 100;
   localparam int MODE_END   = 108;
   localparam int MTIME_FIRST = 136;
   localparam int CK_FIRST   = 148;
   localparam int CK_LAST    = 155;
   localparam int MAGIC_AT   = 257;
   localparam int POSIX_LEN  = 6;
   localparam int GNU_LEN    = 8;

   // archive format codes
   localparam logic [1:0] FMT_V7     = 2'd0;
   localparam logic [1:0] FMT_OLDGNU = 2'd1;
   localparam logic [1:0] FMT_POSIX  = 2'd2;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_DEL   = 8'h80;

   typedef struct packed {
      logic       header_valid;
      logic [1:0] hdr_format;
   } verdict_type;

   typedef struct packed {
      logic       take;
      logic       last_byte;
      logic [7:0] data_byte;
   } word_type;

   function automatic logic [7:0] posix_magic_byte(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h75;
         3'd1: ch = 8'h73;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h61;
         3'd4: ch = 8'h72;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] gnu_magic_byte(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h75;
         3'd1: ch = 8'h73;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h61;
         3'd4: ch = 8'h72;
         3'd5: ch = 8'h20;
         3'd6: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_octal(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_SEVEN);
   endfunction

endpackage

// File: hw/rtl/tarhv_accum.sv
`timescale 1ns / 1ps

module tarhv_accum
   import tarhv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  word_type    word,
   output verdict_type verdict
);

   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             name_open_ff, name_open_in;
   logic             mtime_open_ff, mtime_open_in;
   logic             reject_ff, reject_in;
   logic             posix_ok_ff, posix_ok_in;
   logic             gnu_ok_ff, gnu_ok_in;
   logic [1:0]       phase_ff, phase_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             neg_ff, neg_in;

   always_comb begin
      logic [7:0]       b;
      logic [OFS_W-1:0] o;
      logic [OFS_W-1:0] mofs;
      logic [2:0]       digit;
      b     = word.data_byte;
      o     = ofs_ff;
      mofs  = o - OFS_W'(MAGIC_AT);
      digit = b[2:0];

      ofs_in        = ofs_ff;
      sum_in        = sum_ff;
      name_open_in  = name_open_ff;
      mtime_open_in = mtime_open_ff;
      reject_in     = reject_ff;
      posix_ok_in   = posix_ok_ff;
      gnu_ok_in     = gnu_ok_ff;
      phase_in      = phase_ff;
      value_in      = value_ff;
      neg_in        = neg_ff;

      if (o < OFS_W'(HDR_LEN)) begin
         // name, mtime: no control or high byte before the first nul
         if (o < OFS_W'(MODE_FIRST)) begin
            if (name_open_ff) begin
               if (b == 8'h00) begin
                  name_open_in = 1'b0;
               end else if (b < CH_SPACE || b >= CH_DEL) begin
                  reject_in = 1'b1;
               end
            end
         end else if (o < OFS_W'(MODE_END)) begin
            if (!(b == 8'h00 || b == CH_SPACE || is_octal(b))) begin
               reject_in = 1'b1;
            end
         end else if (o >= OFS_W'(MTIME_FIRST) && o < OFS_W'(CK_FIRST)) begin
            if (mtime_open_ff) begin
               if (b == 8'h00) begin
                  mtime_open_in = 1'b0;
               end else if (b < CH_SPACE || b >= CH_DEL) begin
                  reject_in = 1'b1;
               end
            end
         end

         if (o >= OFS_W'(CK_FIRST) && o <= OFS_W'(CK_LAST)) begin
            case (phase_ff)
               PH_SKIP: begin
                  if (b == CH_TAB || b == CH_CR || b == CH_SPACE) begin
                     phase_in = PH_SKIP;
                  end else if (b == CH_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_DIGITS;
                  end else if (b == CH_PLUS) begin
                     phase_in = PH_DIGITS;
                  end else if (is_octal(b)) begin
                     value_in = {{(VAL_W-3){1'b0}}, digit};
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (is_octal(b)) begin
                     value_in = {value_ff[VAL_W-4:0], digit};
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end else begin
            sum_in = sum_ff + {{(SUM_W-8){1'b0}}, b};
         end

         if (o >= OFS_W'(MAGIC_AT) && o < OFS_W'(MAGIC_AT + POSIX_LEN)
             && b != posix_magic_byte(mofs[2:0])) begin
            posix_ok_in = 1'b0;
         end
         if (o >= OFS_W'(MAGIC_AT) && o < OFS_W'(MAGIC_AT + GNU_LEN)
             && b != gnu_magic_byte(mofs[2:0])) begin
            gnu_ok_in = 1'b0;
         end

         ofs_in = o + OFS_W'(1);
      end
   end

   // verdict from the state after this word
   always_comb begin
      logic full;
      full = ofs_in >= OFS_W'(HDR_LEN);
      verdict.header_valid = full && !reject_in && !neg_in
                             && (value_in == {{(VAL_W-SUM_W){1'b0}}, sum_in});
      verdict.hdr_format   = !full      ? FMT_V7 :
                             posix_ok_in ? FMT_POSIX :
                             gnu_ok_in   ? FMT_OLDGNU : FMT_V7;
   end

   always_ff @(posedge clock) begin
      if (reset || (word.take && word.last_byte)) begin
         ofs_ff        <= '0;
         sum_ff        <= SUM_W'(SUM_BASE);
         name_open_ff  <= 1'b1;
         mtime_open_ff <= 1'b1;
         reject_ff     <= 1'b0;
         posix_ok_ff   <= 1'b1;
         gnu_ok_ff     <= 1'b1;
         phase_ff      <= PH_SKIP;
         value_ff      <= '0;
         neg_ff        <= 1'b0;
      end else if (word.take) begin
         ofs_ff        <= ofs_in;
         sum_ff        <= sum_in;
         name_open_ff  <= name_open_in;
         mtime_open_ff <= mtime_open_in;
         reject_ff     <= reject_in;
         posix_ok_ff   <= posix_ok_in;
         gnu_ok_ff     <= gnu_ok_in;
         phase_ff      <= phase_in;
         value_ff      <= value_in;
         neg_ff        <= neg_in;
      end
   end

endmodule

// File: hw/rtl/tar_header_validator.sv
`timescale 1ns / 1ps

// tar header validator: takes a tar header one byte per word on req_, with
// req_tlast on the final byte, and returns one verdict word on rsp_ per
// buffer. The verdict says whether the name, mode and mtime fields are clean
// and the octal checksum at offsets 148..155 matches 256 plus the sum of all
// other bytes, and which format the magic at offset 257 shows (v7, old gnu
// or posix ustar). A buffer shorter than 512 bytes is invalid with format v7;
// bytes past offset 511 are ignored. Rate: one byte per cycle unless stalled.
// A byte is captured in the input register and then folded into the running
// checks; the verdict is registered when the check stage takes the last byte.
// The input side stalls only when a last byte reaches the check stage while
// the previous verdict is still held in the result register.
module tar_header_validator
   import tarhv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] header_valid, [2:1] hdr_format, [7:3] zero
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic        rsp_vld_ff, rsp_vld_in;
   verdict_type rsp_data_ff;

   word_type    word;
   verdict_type verdict;
   logic        advance;

   // the check stage stalls only for a last byte while a verdict is still held
   assign advance    = !(in_vld_ff && in_last_ff && rsp_vld_ff && !rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   assign in_vld_in = req_tready ? req_tvalid : in_vld_ff;

   assign word.take      = in_vld_ff && advance;
   assign word.last_byte = in_last_ff;
   assign word.data_byte = in_byte_ff;

   assign rsp_vld_in = (word.take && in_last_ff) ? 1'b1 :
                       rsp_tready               ? 1'b0 : rsp_vld_ff;

   tarhv_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .word    (word),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (word.take && in_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.hdr_format, rsp_data_ff.header_valid};

endmodule

// File: hw/rtl/tarhv_checker.sv
`timescale 1ns / 1ps

module tarhv_checker
   import tarhv_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // no verdict right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("verdict shown after reset");

   // input only stalls behind a held verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a pending verdict");

   // format code is one of the defined codes and padding is zero
   a_fmt_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:1] == FMT_V7 || rsp_tdata[2:1] == FMT_OLDGNU
                      || rsp_tdata[2:1] == FMT_POSIX) && rsp_tdata[7:3] == 5'd0)
      else $error("bad verdict encoding");

   // a held verdict stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed while stalled");

endmodule

bind tar_header_validator tarhv_checker u_checker (.*);
